### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/ktnvs_pkg.sv
// ----------------------------------------------------------------------------
// ktnvs_pkg
// Shared types, operation codes and key helpers for the keyed table search.
// ----------------------------------------------------------------------------
package ktnvs_pkg;

	localparam int SLOTS_DEF     = 64;
	localparam int KEY_BYTES_DEF = 8;

	localparam int KEY_W  = 64;
	localparam int VAL_W  = 32;
	localparam int OP_W   = 3;
	localparam int LEN_W  = 4;
	localparam int IDX_W  = 6;
	localparam int DATA_W = 104;

	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_EXACT  = 3'd2;
	localparam logic [OP_W-1:0] OP_BELOW  = 3'd3;
	localparam logic [OP_W-1:0] OP_ABOVE  = 3'd4;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] clen;
		logic [VAL_W-1:0] probe;
	} cmd_t;

	// Keep the low kb bytes and clear everything from the first zero byte on.
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k, input int kb);
		logic [KEY_W-1:0] r;
		logic             live;
		r    = '0;
		live = 1'b1;
		for (int b = 0; b < 8; b++) begin
			if (k[8*b +: 8] == 8'h00 || b >= kb) begin
				live = 1'b0;
			end
			if (live) begin
				r[8*b +: 8] = k[8*b +: 8];
			end
		end
		return r;
	endfunction

	// One bit per key byte that takes part in a prefix compare.
	function automatic logic [7:0] prefix_mask(input logic [LEN_W-1:0] clen, input int kb);
		logic [7:0] m;
		for (int b = 0; b < 8; b++) begin
			m[b] = (b < int'(clen)) && (b < kb);
		end
		return m;
	endfunction

endpackage

### sv/ktnvs_store.sv
// ----------------------------------------------------------------------------
// ktnvs_store
// Single-port-write, single-port-read table memory with a registered read.
// ----------------------------------------------------------------------------
module ktnvs_store
	import ktnvs_pkg::*;
#(
	parameter int  SLOTS = SLOTS_DEF,
	localparam int AW    = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/ktnvs_scan.sv
// ----------------------------------------------------------------------------
// ktnvs_scan
// Compares each entry read from the table and keeps the best match so far.
// ----------------------------------------------------------------------------
module ktnvs_scan
	import ktnvs_pkg::*;
#(
	parameter int  SLOTS     = SLOTS_DEF,
	parameter int  KEY_BYTES = KEY_BYTES_DEF,
	localparam int AW        = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cmd_t          cmd,
	input  logic          rd_valid,
	input  logic [AW-1:0] rd_idx,
	input  entry_t        rd_entry,
	output logic          hit,
	output logic [AW-1:0] hit_idx,
	output entry_t        hit_entry
);

	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	entry_t           hit_entry_q;
	logic [VAL_W-1:0] best_q;

	logic [7:0]       mask;
	logic             key_eq;
	logic             pre_eq;
	logic             take;
	logic [VAL_W-1:0] v;

	always_comb begin
		mask   = prefix_mask(cmd.clen, KEY_BYTES);
		key_eq = (rd_entry.key == cmd.key);
		pre_eq = 1'b1;
		for (int b = 0; b < 8; b++) begin
			if (mask[b] && rd_entry.key[8*b +: 8] != cmd.key[8*b +: 8]) begin
				pre_eq = 1'b0;
			end
		end
		v    = rd_entry.value;
		take = 1'b0;
		unique case (cmd.op)
			OP_EXACT: take = key_eq && !hit_q;
			OP_BELOW: take = pre_eq && (v < cmd.probe) && (best_q <= v);
			OP_ABOVE: take = pre_eq && (v > cmd.probe) && (best_q >= v);
			default:  take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (start) begin
			hit_q <= 1'b0;
		end else if (rd_valid && take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			best_q <= (cmd.op == OP_ABOVE) ? VAL_MAX : '0;
		end else if (rd_valid && take) begin
			best_q      <= v;
			hit_idx_q   <= rd_idx;
			hit_entry_q <= rd_entry;
		end
	end

	assign hit       = hit_q;
	assign hit_idx   = hit_idx_q;
	assign hit_entry = hit_entry_q;

endmodule

### sv/keyed_table_nearest_value_search.sv
// ----------------------------------------------------------------------------
// keyed_table_nearest_value_search
// Keyed table with clear, insert, exact lookup and nearest-value searches.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one operation in s_tuser and
// yields exactly one result on the master stream. Clear, insert and unknown
// operations pass from acceptance through the DONE state into the output
// register. Lookups read the table memory one slot per cycle through its
// single read port, stepping through SCAN, DRAIN and DONE (straight to DONE
// on an empty table). Inserts always go to the lowest free slot and nothing
// is ever deleted but by clear, so the filled slots are always a contiguous
// run from slot 0 and a fill count stands in for per-slot valid marks;
// clear takes effect at once and needs no sweep of the memory. A new
// request is taken as soon as the previous result has moved into the output
// register, even if the master side has not yet taken it. Keys are
// normalised on entry: only the low KEY_BYTES bytes are kept and every byte
// after the first zero byte is cleared. A miss returns found low with
// index, key and value all zero.
// ----------------------------------------------------------------------------
module keyed_table_nearest_value_search
	import ktnvs_pkg::*;
#(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Request stream
	input  logic              s_tvalid,
	output logic              s_tready,
	// search_key [63:0], compare_len [67:64], probe_value [99:68], zero [103:100]
	input  logic [DATA_W-1:0] s_tdata,
	// op [2:0]
	input  logic [OP_W-1:0]   s_tuser,
	// Result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	// entry_index [5:0], entry_key [69:6], entry_value [101:70], zero [103:102]
	output logic [DATA_W-1:0] m_tdata,
	// found [0]
	output logic              m_tuser
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    rd_addr_q;
	logic             rd_valid_s1;
	logic [AW-1:0]    rd_idx_s1;
	cmd_t             cmd_q;
	logic             ins_ok_q;
	logic [AW-1:0]    ins_idx_q;

	logic             m_tvalid_q;
	logic             res_found_q;
	logic [IDX_W-1:0] res_idx_q;
	entry_t           res_entry_q;

	cmd_t             in_cmd;
	logic             accept;
	logic             table_full;
	logic             last_issue;
	logic             out_free;
	logic             scan_start;
	logic             mem_we;
	entry_t           mem_wdata;
	entry_t           mem_rdata;
	logic             scan_hit;
	logic [AW-1:0]    scan_idx;
	entry_t           scan_entry;

	logic             res_found;
	logic [IDX_W-1:0] res_idx;
	entry_t           res_entry;

	// Request fields, with the key normalised before it is stored or compared.
	always_comb begin
		in_cmd.op    = s_tuser;
		in_cmd.key   = norm_key(s_tdata[KEY_W-1:0], KEY_BYTES);
		in_cmd.clen  = s_tdata[KEY_W +: LEN_W];
		in_cmd.probe = s_tdata[KEY_W + LEN_W +: VAL_W];
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign table_full = (count_q == CW'(SLOTS));
	assign last_issue = ((CW'(rd_addr_q) + CW'(1)) == count_q);
	assign out_free   = !m_tvalid_q || m_tready;
	// The first read of a scan is issued now; the scan unit sets its running
	// best so that slot 0 meets a fresh starting point in the cycle after.
	assign scan_start = (state_q == ST_SCAN) && (rd_addr_q == '0);

	// An insert is written straight into the next free slot in the cycle the
	// request is accepted; no scan is needed.
	assign mem_we          = accept && (in_cmd.op == OP_INSERT) && !table_full;
	assign mem_wdata.key   = in_cmd.key;
	assign mem_wdata.value = in_cmd.probe;

	ktnvs_store #(
		.SLOTS (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (mem_wdata),
		.re    (state_q == ST_SCAN),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	ktnvs_scan #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.cmd       (cmd_q),
		.rd_valid  (rd_valid_s1),
		.rd_idx    (rd_idx_s1),
		.rd_entry  (mem_rdata),
		.hit       (scan_hit),
		.hit_idx   (scan_idx),
		.hit_entry (scan_entry)
	);

	// Sequencer: one request at a time, scanning the filled slots for lookups.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_addr_q <= '0;
						unique case (in_cmd.op)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							OP_INSERT: begin
								if (!table_full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_DONE;
							end
							OP_EXACT, OP_BELOW, OP_ABOVE: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The last slot read is being compared in this cycle.
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
		if (accept) begin
			cmd_q     <= in_cmd;
			ins_ok_q  <= !table_full;
			ins_idx_q <= count_q[AW-1:0];
		end
	end

	// Result selection. The fill count does not change during a lookup, so a
	// zero count here means the scan never ran and its hit mark is stale.
	always_comb begin
		res_found = 1'b0;
		res_idx   = '0;
		res_entry = '0;
		unique case (cmd_q.op)
			OP_INSERT: begin
				res_found       = ins_ok_q;
				res_idx         = IDX_W'(ins_idx_q);
				res_entry.key   = cmd_q.key;
				res_entry.value = cmd_q.probe;
			end
			OP_EXACT, OP_BELOW, OP_ABOVE: begin
				res_found = scan_hit && (count_q != '0);
				res_idx   = IDX_W'(scan_idx);
				res_entry = scan_entry;
			end
			default: begin
				res_found = 1'b0;
			end
		endcase
		if (!res_found) begin
			res_idx   = '0;
			res_entry = '0;
		end
	end

	// Output register: holds one finished result until the master side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_found_q <= res_found;
			res_idx_q   <= res_idx;
			res_entry_q <= res_entry;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_found_q;
	assign m_tdata  = {(DATA_W - IDX_W - KEY_W - VAL_W)'(0),
		res_entry_q.value, res_entry_q.key, res_idx_q};

endmodule

### sv/ktnvs_checker.sv
// ----------------------------------------------------------------------------
// ktnvs_checker
// Port-level checks on the keyed table search, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ktnvs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic         m_tuser
);

	// A stalled result stays offered and unchanged.
	`KT_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`KT_ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

	// A miss carries an all-zero index, key and value.
	`KT_ASSERT_IMPLY(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 104'd0)

	// Requests are worked on one at a time, so an accepted one closes the input.
	`KT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind keyed_table_nearest_value_search ktnvs_checker u_ktnvs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
